// ===== src/ibc_pkg.sv =====
// Shared types and constants for the IMU bias calibration unit.
`timescale 1ns / 1ps

package ibc_pkg;

  localparam int AXES       = 6;   // acc x, y, z, gyro x, y, z
  localparam int AXIS_ACC_Z = 2;
  localparam int SMP_W      = 16;  // raw sample width
  localparam int TS_W       = 16;  // millisecond timestamp width
  localparam int MAG_W      = 16;  // magnitude of a rounded mean
  localparam int OFF_W      = 17;  // held offset width (z carries one g)
  localparam int INTV_W     = 10;
  localparam int ONE_G_W    = 15;
  localparam int CFG_AW     = 1;
  localparam int CFG_DW     = 15;

  localparam logic [INTV_W-1:0]  INTV_RST  = 10'd10;
  localparam logic [ONE_G_W-1:0] ONE_G_RST = 15'd4096;

  typedef enum logic [CFG_AW-1:0] {
    CFG_INTERVAL = 1'b0,
    CFG_ONE_G    = 1'b1
  } cfg_idx_t;

endpackage

// ===== src/ibc_mean_lane.sv =====
// One axis of the mean stage: divide a rounded magnitude by SAMPLES via reciprocal.
`timescale 1ns / 1ps

module ibc_mean_lane #(
  parameter int SAMPLES = 300,
  parameter int SUM_W   = 25
) (
  input  logic                               clk,
  input  logic                               load,
  input  logic [SUM_W-1:0]                   dividend,  // |sum| + SAMPLES/2
  input  logic                               neg,
  output logic signed [ibc_pkg::OFF_W-1:0]   mean
);

  // floor(n * RECIP / 2^SHIFT) == floor(n / SAMPLES) for every n below 2^SUM_W
  localparam int SHIFT   = SUM_W + $clog2(SAMPLES);
  localparam int RECIP_W = SUM_W + 1;
  localparam int PROD_W  = SUM_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  logic [PROD_W-1:0]         prod;
  logic [ibc_pkg::MAG_W-1:0] quot_r;
  logic                      neg_r;

  assign prod = PROD_W'(dividend) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (load) begin
      quot_r <= prod[SHIFT +: ibc_pkg::MAG_W];
      neg_r  <= neg;
    end
  end

  always_comb begin
    if (neg_r) begin
      mean = -$signed({1'b0, quot_r});
    end else begin
      mean = $signed({1'b0, quot_r});
    end
  end

endmodule

// ===== src/imu_bias_calibration_unit.sv =====
// Top level of the IMU bias calibration unit.
`timescale 1ns / 1ps

// Averages SAMPLES six-axis readings taken at least sample_interval_ms apart and
// holds the rounded means as offsets (z accelerometer less one g). Every accepted
// item gives one result. The unit takes one item per clock while in_stall is low.
// The path has four registers: input register, control and accumulate stage,
// reciprocal multiply per axis, output register. The input register loads at the
// accepting edge. A stalled output holds the output register; an earlier stage
// still loads while it or a later stage is empty. out_done_res and out_ready_res
// are high only on the item that closes a run; the next item opens a new run. The
// offset outputs always show the last finished run (zero before the first one).
module imu_bias_calibration_unit #(
  parameter int SAMPLES = 300
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // configuration
  input  logic                                 cfg_we,
  input  logic [ibc_pkg::CFG_AW-1:0]           cfg_addr,
  input  logic [ibc_pkg::CFG_DW-1:0]           cfg_wdata,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ibc_pkg::TS_W-1:0]             in_now_ms,
  input  logic signed [ibc_pkg::SMP_W-1:0]     in_acc_x,
  input  logic signed [ibc_pkg::SMP_W-1:0]     in_acc_y,
  input  logic signed [ibc_pkg::SMP_W-1:0]     in_acc_z,
  input  logic signed [ibc_pkg::SMP_W-1:0]     in_gyro_x,
  input  logic signed [ibc_pkg::SMP_W-1:0]     in_gyro_y,
  input  logic signed [ibc_pkg::SMP_W-1:0]     in_gyro_z,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_done_res,
  output logic                                 out_ready_res,
  output logic signed [ibc_pkg::SMP_W-1:0]     out_acc_off_x,
  output logic signed [ibc_pkg::SMP_W-1:0]     out_acc_off_y,
  output logic signed [ibc_pkg::OFF_W-1:0]     out_acc_off_z,
  output logic signed [ibc_pkg::SMP_W-1:0]     out_gyro_off_x,
  output logic signed [ibc_pkg::SMP_W-1:0]     out_gyro_off_y,
  output logic signed [ibc_pkg::SMP_W-1:0]     out_gyro_off_z
);

  localparam int CNT_W = $clog2(SAMPLES + 1);
  localparam int SUM_W = ibc_pkg::SMP_W + $clog2(SAMPLES);
  localparam int HALF  = SAMPLES / 2;
  localparam int NAX   = ibc_pkg::AXES;

  // configuration registers
  logic [ibc_pkg::INTV_W-1:0]  intv_r;
  logic [ibc_pkg::ONE_G_W-1:0] one_g_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intv_r  <= ibc_pkg::INTV_RST;
      one_g_r <= ibc_pkg::ONE_G_RST;
    end else if (cfg_we) begin
      case (ibc_pkg::cfg_idx_t'(cfg_addr))
        ibc_pkg::CFG_INTERVAL: intv_r  <= cfg_wdata[ibc_pkg::INTV_W-1:0];
        ibc_pkg::CFG_ONE_G:    one_g_r <= cfg_wdata[ibc_pkg::ONE_G_W-1:0];
        default: ;
      endcase
    end
  end

  // stage handshake: a stage loads when it is empty or its successor moves
  logic p1_v_r, p2_v_r, p3_v_r, out_valid_r;
  logic rdy1, rdy2, rdy3, rdy_out;

  assign rdy_out  = !out_valid_r || !out_stall;
  assign rdy3     = !p3_v_r || rdy_out;
  assign rdy2     = !p2_v_r || rdy3;
  assign rdy1     = !p1_v_r || rdy2;
  assign in_stall = !rdy1;

  // input register
  logic [ibc_pkg::TS_W-1:0]         p1_now_r;
  logic signed [ibc_pkg::SMP_W-1:0] p1_smp_r [NAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
    end else if (rdy1) begin
      p1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      p1_now_r    <= in_now_ms;
      p1_smp_r[0] <= in_acc_x;
      p1_smp_r[1] <= in_acc_y;
      p1_smp_r[2] <= in_acc_z;
      p1_smp_r[3] <= in_gyro_x;
      p1_smp_r[4] <= in_gyro_y;
      p1_smp_r[5] <= in_gyro_z;
    end
  end

  // calibration state, updated as an item leaves the input register
  logic signed [SUM_W-1:0]  sums_r [NAX];
  logic signed [SUM_W-1:0]  sums_nxt [NAX];
  logic [CNT_W-1:0]         cnt_r, cnt_nxt, cnt_eff;
  logic [ibc_pkg::TS_W-1:0] last_r;
  logic                     coll_r, coll_nxt;
  logic                     ov_r, ov_nxt;
  logic [ibc_pkg::TS_W-1:0] dt;
  logic                     due, take, finish, step;
  logic [SUM_W-1:0]         div_nxt [NAX];

  assign step = p1_v_r && rdy2;

  always_comb begin
    dt      = p1_now_r - last_r;
    due     = dt >= ibc_pkg::TS_W'(intv_r);
    // an idle unit opens a run: sums and count start from zero
    cnt_eff = coll_r ? cnt_r : '0;
    take    = due && (cnt_eff < CNT_W'(SAMPLES));
    finish  = due && !take;
    cnt_nxt = cnt_eff + CNT_W'(take);
    for (int i = 0; i < NAX; i++) begin
      sums_nxt[i] = (coll_r ? sums_r[i] : '0) + (take ? SUM_W'(p1_smp_r[i]) : '0);
      // rounded magnitude, halves away from zero
      div_nxt[i]  = (sums_r[i][SUM_W-1] ? SUM_W'(-sums_r[i]) : SUM_W'(sums_r[i]))
                    + SUM_W'(HALF);
    end
    coll_nxt = !finish;
    ov_nxt   = finish || (coll_r && ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      last_r <= '0;
      coll_r <= 1'b0;
      ov_r   <= 1'b0;
      for (int i = 0; i < NAX; i++) begin
        sums_r[i] <= '0;
      end
    end else if (step) begin
      cnt_r  <= cnt_nxt;
      coll_r <= coll_nxt;
      ov_r   <= ov_nxt;
      if (take) begin
        last_r <= p1_now_r;
      end
      for (int i = 0; i < NAX; i++) begin
        sums_r[i] <= sums_nxt[i];
      end
    end
  end

  // stage 2: dividends of every item; only those of a closing item are used
  logic             p2_done_r, p2_ready_r;
  logic [SUM_W-1:0] p2_div_r [NAX];
  logic             p2_neg_r [NAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p2_v_r <= 1'b0;
    end else if (rdy2) begin
      p2_v_r <= p1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      p2_done_r  <= finish;
      p2_ready_r <= ov_nxt && !coll_nxt;
      for (int i = 0; i < NAX; i++) begin
        p2_div_r[i] <= div_nxt[i];
        p2_neg_r[i] <= sums_r[i][SUM_W-1];
      end
    end
  end

  // stage 3: per-axis means
  logic                             p3_done_r, p3_ready_r;
  logic signed [ibc_pkg::OFF_W-1:0] mean [NAX];

  for (genvar g = 0; g < NAX; g++) begin : g_lane
    ibc_mean_lane #(
      .SAMPLES (SAMPLES),
      .SUM_W   (SUM_W)
    ) u_lane (
      .clk      (clk),
      .load     (rdy3),
      .dividend (p2_div_r[g]),
      .neg      (p2_neg_r[g]),
      .mean     (mean[g])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p3_v_r <= 1'b0;
    end else if (rdy3) begin
      p3_v_r <= p2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3) begin
      p3_done_r  <= p2_done_r;
      p3_ready_r <= p2_ready_r;
    end
  end

  // output register; the held offsets change only with a closing item
  logic                             out_done_r, out_ready_r;
  logic signed [ibc_pkg::OFF_W-1:0] held_r [NAX];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      out_done_r  <= 1'b0;
      out_ready_r <= 1'b0;
      for (int i = 0; i < NAX; i++) begin
        held_r[i] <= '0;
      end
    end else if (rdy_out) begin
      out_valid_r <= p3_v_r;
      out_done_r  <= p3_done_r;
      out_ready_r <= p3_ready_r;
      if (p3_v_r && p3_done_r) begin
        for (int i = 0; i < NAX; i++) begin
          if (i == ibc_pkg::AXIS_ACC_Z) begin
            held_r[i] <= mean[i] - $signed({2'b00, one_g_r});
          end else begin
            held_r[i] <= mean[i];
          end
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_done_res   = out_done_r;
  assign out_ready_res  = out_ready_r;
  assign out_acc_off_x  = held_r[0][ibc_pkg::SMP_W-1:0];
  assign out_acc_off_y  = held_r[1][ibc_pkg::SMP_W-1:0];
  assign out_acc_off_z  = held_r[ibc_pkg::AXIS_ACC_Z];
  assign out_gyro_off_x = held_r[3][ibc_pkg::SMP_W-1:0];
  assign out_gyro_off_y = held_r[4][ibc_pkg::SMP_W-1:0];
  assign out_gyro_off_z = held_r[5][ibc_pkg::SMP_W-1:0];

endmodule

// ===== tb/tb_imu_bias_calibration_unit.sv =====
// Self-checking testbench for the IMU bias calibration unit.
`timescale 1ns / 1ps

module tb_imu_bias_calibration_unit;

  localparam int SAMPLES  = 300;
  localparam int HOLD_CYC = 90;  // long output hold, enough to back up the input

  typedef struct packed {
    logic [ibc_pkg::TS_W-1:0]  now;
    logic [ibc_pkg::SMP_W-1:0] ax, ay, az, gx, gy, gz;
  } imu_item_t;

  typedef struct packed {
    logic                      done;
    logic                      ready;
    logic [ibc_pkg::SMP_W-1:0] ax, ay;
    logic [ibc_pkg::OFF_W-1:0] az;
    logic [ibc_pkg::SMP_W-1:0] gx, gy, gz;
  } offsets_t;

  typedef struct packed {
    imu_item_t item;
    offsets_t  want;
  } dir_row_t;

  typedef enum {RUN_RAND, RUN_MIN, RUN_MAX, RUN_HALF, RUN_NOISE} run_mode_t;
  typedef enum {RX_FREE, RX_SPARSE, RX_PATTERN, RX_HEAVY} rx_mode_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [ibc_pkg::CFG_AW-1:0] cfg_addr;
  logic [ibc_pkg::CFG_DW-1:0] cfg_wdata;
  logic in_valid, in_stall;
  logic [ibc_pkg::TS_W-1:0] in_now_ms;
  logic signed [ibc_pkg::SMP_W-1:0] in_acc_x, in_acc_y, in_acc_z;
  logic signed [ibc_pkg::SMP_W-1:0] in_gyro_x, in_gyro_y, in_gyro_z;
  logic out_valid, out_stall;
  logic out_done_res, out_ready_res;
  logic signed [ibc_pkg::SMP_W-1:0] out_acc_off_x, out_acc_off_y;
  logic signed [ibc_pkg::OFF_W-1:0] out_acc_off_z;
  logic signed [ibc_pkg::SMP_W-1:0] out_gyro_off_x, out_gyro_off_y, out_gyro_off_z;

  always #5 clk = ~clk;

  imu_bias_calibration_unit #(.SAMPLES(SAMPLES)) u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_now_ms      (in_now_ms),
    .in_acc_x       (in_acc_x),
    .in_acc_y       (in_acc_y),
    .in_acc_z       (in_acc_z),
    .in_gyro_x      (in_gyro_x),
    .in_gyro_y      (in_gyro_y),
    .in_gyro_z      (in_gyro_z),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_done_res   (out_done_res),
    .out_ready_res  (out_ready_res),
    .out_acc_off_x  (out_acc_off_x),
    .out_acc_off_y  (out_acc_off_y),
    .out_acc_off_z  (out_acc_off_z),
    .out_gyro_off_x (out_gyro_off_x),
    .out_gyro_off_y (out_gyro_off_y),
    .out_gyro_off_z (out_gyro_off_z)
  );

  // calibrator state as the testbench sees it
  logic signed [24:0]          bias_sum [ibc_pkg::AXES];
  logic [8:0]                  bias_cnt;
  logic [ibc_pkg::TS_W-1:0]    bias_last_ts;
  logic                        bias_busy;
  logic                        bias_valid;
  int                          bias_held [ibc_pkg::AXES];
  logic [ibc_pkg::INTV_W-1:0]  bias_intv;
  logic [ibc_pkg::ONE_G_W-1:0] bias_one_g;

  offsets_t  offsets_due [$];
  int        errors = 0;
  int        items_sent = 0;
  int        results_seen = 0;
  int        runs_done = 0;
  int        cfg_sets = 1;
  logic      hold_req = 1'b0;
  logic [ibc_pkg::TS_W-1:0] ts_now = '0;
  run_mode_t cur_mode = RUN_RAND;
  run_mode_t next_mode = RUN_RAND;
  int        run_center [ibc_pkg::AXES];
  int        run_bump [ibc_pkg::AXES];
  rx_mode_t  rx_mode = RX_FREE;
  int        rx_cyc = 0;
  offsets_t  got, want;

  // directed items, default interval of 10 ms; no run can finish here, so
  // every result shows zero offsets and ready low
  dir_row_t dir_rows [16] = '{
    '{'{16'd0,     16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, '0},
    '{'{16'd9,     16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, '0},
    '{'{16'd10,    16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF}, '0},
    '{'{16'd15,    16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, '0},
    '{'{16'd20,    16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000}, '0},
    '{'{16'd65535, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555, 16'h5555}, '0},
    '{'{16'd4,     16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA}, '0},
    '{'{16'd9,     16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA, 16'hAAAA}, '0},
    '{'{16'd9,     16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, '0},
    '{'{16'd18,    16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001, 16'h0001}, '0},
    '{'{16'd19,    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF}, '0},
    '{'{16'd32768, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000}, '0},
    '{'{16'd32777, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF}, '0},
    '{'{16'd32778, 16'h1234, 16'hEDCC, 16'h0000, 16'h7FFF, 16'h8000, 16'h0001}, '0},
    '{'{16'd65535, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000}, '0},
    '{'{16'd65535, 16'h0F0F, 16'hF0F0, 16'h00FF, 16'hFF00, 16'h3C3C, 16'hC3C3}, '0}
  };

  function automatic void bias_reset();
    for (int i = 0; i < ibc_pkg::AXES; i++) begin
      bias_sum[i]  = '0;
      bias_held[i] = 0;
    end
    bias_cnt     = '0;
    bias_last_ts = '0;
    bias_busy    = 1'b0;
    bias_valid   = 1'b0;
    bias_intv    = ibc_pkg::INTV_RST;
    bias_one_g   = ibc_pkg::ONE_G_RST;
  endfunction

  function automatic offsets_t bias_step(imu_item_t it);
    logic signed [ibc_pkg::SMP_W-1:0] smp [ibc_pkg::AXES];
    logic [ibc_pkg::TS_W-1:0] dt;
    longint mag, q, cnt;
    offsets_t r;
    smp = '{it.ax, it.ay, it.az, it.gx, it.gy, it.gz};
    dt = it.now - bias_last_ts;
    r.done = 1'b0;
    if (!bias_busy) begin
      bias_busy  = 1'b1;
      bias_valid = 1'b0;
      bias_cnt   = '0;
      for (int i = 0; i < ibc_pkg::AXES; i++) bias_sum[i] = '0;
    end
    if (dt >= bias_intv) begin
      if (bias_cnt < SAMPLES) begin
        for (int i = 0; i < ibc_pkg::AXES; i++) bias_sum[i] = bias_sum[i] + smp[i];
        bias_cnt     = bias_cnt + 1'b1;
        bias_last_ts = it.now;
      end else begin
        // closing item: its samples are dropped, means rounded half away from zero
        cnt = longint'(bias_cnt);
        for (int i = 0; i < ibc_pkg::AXES; i++) begin
          mag = (bias_sum[i] < 0) ? -longint'(bias_sum[i]) : longint'(bias_sum[i]);
          q   = (cnt == 0) ? 0 : (mag + cnt / 2) / cnt;
          bias_held[i] = int'((bias_sum[i] < 0) ? -q : q);
        end
        bias_held[ibc_pkg::AXIS_ACC_Z] = bias_held[ibc_pkg::AXIS_ACC_Z] - int'(bias_one_g);
        bias_busy  = 1'b0;
        bias_valid = 1'b1;
        r.done     = 1'b1;
      end
    end
    r.ready = bias_valid && !bias_busy;
    r.ax    = bias_held[0][ibc_pkg::SMP_W-1:0];
    r.ay    = bias_held[1][ibc_pkg::SMP_W-1:0];
    r.az    = bias_held[ibc_pkg::AXIS_ACC_Z][ibc_pkg::OFF_W-1:0];
    r.gx    = bias_held[3][ibc_pkg::SMP_W-1:0];
    r.gy    = bias_held[4][ibc_pkg::SMP_W-1:0];
    r.gz    = bias_held[5][ibc_pkg::SMP_W-1:0];
    return r;
  endfunction

  function automatic imu_item_t make_item(logic [ibc_pkg::TS_W-1:0] now);
    logic [ibc_pkg::SMP_W-1:0] v [ibc_pkg::AXES];
    imu_item_t it;
    for (int i = 0; i < ibc_pkg::AXES; i++) begin
      case (cur_mode)
        RUN_RAND:  v[i] = ibc_pkg::SMP_W'($urandom);
        RUN_MIN:   v[i] = 16'h8000;
        RUN_MAX:   v[i] = 16'h7FFF;
        // only the first taken sample of the run carries the bump
        RUN_HALF:  v[i] = ibc_pkg::SMP_W'(run_center[i] +
                                 ((!bias_busy || bias_cnt == 0) ? run_bump[i] : 0));
        default:   v[i] = ibc_pkg::SMP_W'(run_center[i] + int'($urandom_range(200)) - 100);
      endcase
    end
    it.now = now;
    it.ax  = v[0];
    it.ay  = v[1];
    it.az  = v[2];
    it.gx  = v[3];
    it.gy  = v[4];
    it.gz  = v[5];
    return it;
  endfunction

  function automatic string offsets_str(offsets_t r);
    return $sformatf("done=%b ready=%b acc=%0d,%0d,%0d gyro=%0d,%0d,%0d",
                     r.done, r.ready, $signed(r.ax), $signed(r.ay), $signed(r.az),
                     $signed(r.gx), $signed(r.gy), $signed(r.gz));
  endfunction

  task automatic send_item(imu_item_t it, logic typed, offsets_t typed_res);
    offsets_t pred;
    @(negedge clk);
    in_valid  <= 1'b1;
    in_now_ms <= it.now;
    in_acc_x  <= it.ax;
    in_acc_y  <= it.ay;
    in_acc_z  <= it.az;
    in_gyro_x <= it.gx;
    in_gyro_y <= it.gy;
    in_gyro_z <= it.gz;
    do @(posedge clk); while (in_stall !== 1'b0);
    pred = bias_step(it);
    offsets_due.push_back(typed ? typed_res : pred);
    items_sent++;
    if (pred.done) begin
      runs_done++;
      cur_mode = next_mode;
      for (int i = 0; i < ibc_pkg::AXES; i++) begin
        run_center[i] = int'($urandom_range(60000)) - 30000;
        run_bump[i]   = $urandom_range(1) ? SAMPLES / 2 : -(SAMPLES / 2);
      end
    end
  endtask

  task automatic idle_gap(int n);
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic cfg_write(ibc_pkg::cfg_idx_t idx, logic [ibc_pkg::CFG_DW-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      ibc_pkg::CFG_INTERVAL: bias_intv  = data[ibc_pkg::INTV_W-1:0];
      ibc_pkg::CFG_ONE_G:    bias_one_g = data[ibc_pkg::ONE_G_W-1:0];
      default: ;
    endcase
  endtask

  // drains, reprograms, then streams items until one run closes plus a short tail
  task automatic run_phase(logic [ibc_pkg::CFG_DW-1:0] intv_w,
                           logic [ibc_pkg::CFG_DW-1:0] one_g_w,
                           run_mode_t mode, int hold_at);
    int n, tail, burst_left, no_gap_left, r;
    int step;
    int intv;
    idle_gap(1);
    while (offsets_due.size() != 0) @(posedge clk);
    cfg_write(ibc_pkg::CFG_INTERVAL, intv_w);
    cfg_write(ibc_pkg::CFG_ONE_G, one_g_w);
    cfg_sets++;
    intv        = int'(intv_w[ibc_pkg::INTV_W-1:0]);
    next_mode   = mode;
    n           = 0;
    tail        = -1;
    burst_left  = 0;
    no_gap_left = 0;
    while (tail != 0 && n < 900) begin
      if (n == hold_at) begin
        hold_req    = 1'b1;
        no_gap_left = HOLD_CYC;
      end
      if (no_gap_left > 0) begin
        no_gap_left--;
      end else if (burst_left == 0) begin
        if ($urandom_range(3) != 0) idle_gap($urandom_range(1, 8));
        burst_left = ($urandom_range(9) == 0) ? $urandom_range(100, 200)
                                               : $urandom_range(1, 24);
      end else begin
        burst_left--;
      end
      r = $urandom_range(99);
      if (r < 84)
        step = intv + (($urandom_range(3) == 0) ? 0 : $urandom_range(4));
      else if (r < 95 && intv != 0)
        step = $urandom_range(intv - 1);
      else
        step = $urandom;
      ts_now = ts_now + ibc_pkg::TS_W'(step);
      send_item(make_item(ts_now), 1'b0, '0);
      n++;
      if (tail > 0)
        tail--;
      else if (tail < 0 && !bias_busy && bias_valid)
        tail = $urandom_range(5, 25);
    end
  endtask

  // result side: random stall patterns, plus a long hold on request
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      rx_cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYC) @(negedge clk);
        out_stall <= 1'b0;
      end else begin
        if (rx_cyc % 150 == 0) rx_mode = rx_mode_t'($urandom_range(3));
        case (rx_mode)
          RX_FREE:    out_stall <= 1'b0;
          RX_SPARSE:  out_stall <= ($urandom_range(9) < 3);
          RX_PATTERN: out_stall <= (rx_cyc % 5 >= 3);
          default:    out_stall <= ($urandom_range(9) < 7);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      got = '{out_done_res, out_ready_res, out_acc_off_x, out_acc_off_y, out_acc_off_z,
              out_gyro_off_x, out_gyro_off_y, out_gyro_off_z};
      results_seen++;
      if (offsets_due.size() == 0) begin
        if (errors < 10) $display("unexpected result: %s", offsets_str(got));
        errors++;
      end else begin
        want = offsets_due.pop_front();
        if (got !== want) begin
          if (errors < 10) begin
            $display("result %0d mismatch", results_seen);
            $display("  expected %s", offsets_str(want));
            $display("  actual   %s", offsets_str(got));
          end
          errors++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", offsets_due.size());
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = ibc_pkg::CFG_INTERVAL;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_now_ms = '0;
    in_acc_x  = '0;
    in_acc_y  = '0;
    in_acc_z  = '0;
    in_gyro_x = '0;
    in_gyro_y = '0;
    in_gyro_z = '0;
    bias_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_rows[k]) begin
      if (k % 5 == 4) idle_gap(2);
      send_item(dir_rows[k].item, 1'b1, dir_rows[k].want);
    end
    ts_now = dir_rows[15].item.now;

    // each run closes under the next phase's settings
    run_phase(15'd0, 15'd0, RUN_MIN, 100);
    run_phase(15'd1, 15'd32767, RUN_HALF, -1);
    run_phase({5'b10101, 10'd1023}, ibc_pkg::ONE_G_W'($urandom), RUN_MAX, 50);
    run_phase(15'd1000, 15'd16384, RUN_NOISE, -1);
    run_phase(ibc_pkg::CFG_DW'($urandom_range(2, 40)), ibc_pkg::ONE_G_W'($urandom),
              RUN_RAND, -1);

    idle_gap(1);
    while (offsets_due.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
    errors += offsets_due.size();

    $display("%0d items sent, %0d results checked, %0d calibration runs closed",
             items_sent, results_seen, runs_done);
    $display("%0d register settings incl. zero and 1023 ms intervals; %0d mismatches",
             cfg_sets, errors);
    if (errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== imu_bias_calibration_unit.f =====
src/ibc_pkg.sv
src/ibc_mean_lane.sv
src/imu_bias_calibration_unit.sv
tb/tb_imu_bias_calibration_unit.sv
